@@ design/rdl_pkg.sv @@
// ----------------------------------------------------------------------------
// rdl_pkg: shared types and constants for the disk light intersector
// Holds register codes, configuration bundles, the queue word and the
// stage records of the two pipelined dividers.
// ----------------------------------------------------------------------------
package rdl_pkg;

  // pi in Q16.16, rounded to nearest
  localparam logic [17:0] PI_Q16 = 18'd205887;

  // largest Q16.16 distance the result field can carry
  localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;
  localparam logic [31:0] DENS_MAX = 32'hFFFF_FFFF;

  // configuration register codes
  typedef enum logic [2:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_NORMAL_X = 3'd3,
    REG_NORMAL_Y = 3'd4,
    REG_NORMAL_Z = 3'd5,
    REG_RADIUS   = 3'd6
  } cfg_reg_t;

  // disk placement used by the front end
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [17:0] nz;
  } geom_cfg_t;

  // radius terms used by the back end
  typedef struct packed {
    logic [30:0] radius;
    logic [61:0] rad_sq;
    logic [79:0] pi_rad_sq;
  } disk_cfg_t;

  // classified ray, passed from front to back through the queue
  typedef struct packed {
    logic               miss;
    logic [35:0]        den;    // -(dir . normal)
    logic [50:0]        num;    // (origin - center) . normal
    logic signed [32:0] off_x;  // origin - center
    logic signed [32:0] off_y;
    logic signed [32:0] off_z;
    logic signed [17:0] dir_x;
    logic signed [17:0] dir_y;
    logic signed [17:0] dir_z;
  } ray_word_t;

  // one stage of the distance divider
  typedef struct packed {
    logic               v;
    logic               miss;
    logic [35:0]        den;
    logic [19:0]        nlo;
    logic [35:0]        rem;
    logic [35:0]        quo;
    logic signed [32:0] off_x;
    logic signed [32:0] off_y;
    logic signed [32:0] off_z;
    logic signed [17:0] dir_x;
    logic signed [17:0] dir_y;
    logic signed [17:0] dir_z;
  } qdiv_t;

  // one stage of the density divider
  typedef struct packed {
    logic         v;
    logic         miss;
    logic         sat;
    logic [35:0]  quo;
    logic [115:0] dn;
    logic [115:0] rem;
    logic [31:0]  dq;
  } ddiv_t;

endpackage

@@ design/rdl_front.sv @@
// ----------------------------------------------------------------------------
// rdl_front: ray intake and classification
// Forms origin offsets and both plane dot products over two stages, then
// flags rays that face away from or run parallel to the plane, or start behind it.
// ----------------------------------------------------------------------------
module rdl_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [31:0]       in_origin_x,
  input  logic signed [31:0]       in_origin_y,
  input  logic signed [31:0]       in_origin_z,
  input  logic signed [17:0]       in_dir_x,
  input  logic signed [17:0]       in_dir_y,
  input  logic signed [17:0]       in_dir_z,
  input  rdl_pkg::geom_cfg_t       geom,
  input  logic                     push_ok,
  output logic                     push_valid,
  output rdl_pkg::ray_word_t       push_word
);
  import rdl_pkg::*;

  logic               adv;
  logic               f1_v_r;
  logic signed [32:0] f1_off_x_r, f1_off_y_r, f1_off_z_r;
  logic signed [17:0] f1_dir_x_r, f1_dir_y_r, f1_dir_z_r;
  logic               f2_v_r;
  logic signed [35:0] f2_pd_x_r, f2_pd_y_r, f2_pd_z_r;
  logic signed [50:0] f2_pn_x_r, f2_pn_y_r, f2_pn_z_r;
  logic signed [32:0] f2_off_x_r, f2_off_y_r, f2_off_z_r;
  logic signed [17:0] f2_dir_x_r, f2_dir_y_r, f2_dir_z_r;
  logic signed [36:0] dn_sum;
  logic signed [51:0] num_sum;
  logic signed [36:0] den_neg;

  // advance the whole front whenever the queue has room
  assign adv      = push_ok;
  assign in_ready = adv;

  // stage 1: offsets of the origin from the disk centre
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (adv) begin
      f1_v_r     <= in_valid;
      f1_off_x_r <= {in_origin_x[31], in_origin_x} - {geom.cx[31], geom.cx};
      f1_off_y_r <= {in_origin_y[31], in_origin_y} - {geom.cy[31], geom.cy};
      f1_off_z_r <= {in_origin_z[31], in_origin_z} - {geom.cz[31], geom.cz};
      f1_dir_x_r <= in_dir_x;
      f1_dir_y_r <= in_dir_y;
      f1_dir_z_r <= in_dir_z;
    end
  end

  // stage 2: per-axis products with the normal
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_v_r <= 1'b0;
    end else if (adv) begin
      f2_v_r     <= f1_v_r;
      f2_pd_x_r  <= f1_dir_x_r * geom.nx;
      f2_pd_y_r  <= f1_dir_y_r * geom.ny;
      f2_pd_z_r  <= f1_dir_z_r * geom.nz;
      f2_pn_x_r  <= f1_off_x_r * geom.nx;
      f2_pn_y_r  <= f1_off_y_r * geom.ny;
      f2_pn_z_r  <= f1_off_z_r * geom.nz;
      f2_off_x_r <= f1_off_x_r;
      f2_off_y_r <= f1_off_y_r;
      f2_off_z_r <= f1_off_z_r;
      f2_dir_x_r <= f1_dir_x_r;
      f2_dir_y_r <= f1_dir_y_r;
      f2_dir_z_r <= f1_dir_z_r;
    end
  end

  // sum the dot products and classify the word
  always_comb begin
    dn_sum  = 37'(f2_pd_x_r) + 37'(f2_pd_y_r) + 37'(f2_pd_z_r);
    num_sum = 52'(f2_pn_x_r) + 52'(f2_pn_y_r) + 52'(f2_pn_z_r);
    den_neg = -dn_sum;
    push_word.miss  = !dn_sum[36] || (dn_sum == '0) || num_sum[51];
    push_word.den   = den_neg[35:0];
    push_word.num   = num_sum[50:0];
    push_word.off_x = f2_off_x_r;
    push_word.off_y = f2_off_y_r;
    push_word.off_z = f2_off_z_r;
    push_word.dir_x = f2_dir_x_r;
    push_word.dir_y = f2_dir_y_r;
    push_word.dir_z = f2_dir_z_r;
  end

  assign push_valid = f2_v_r && adv;

endmodule

@@ design/rdl_queue.sv @@
// ----------------------------------------------------------------------------
// rdl_queue: short word queue between front and back
// Register file with read and write pointers and an occupancy count.
// ----------------------------------------------------------------------------
module rdl_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rdl_pkg::ray_word_t push_word,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output rdl_pkg::ray_word_t head_word
);
  import rdl_pkg::*;

  localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  ray_word_t        mem_r [DEPTH];
  logic [IDXW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [IDXW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNTW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_word = mem_r[rd_ptr_r];

  // advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == IDXW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == IDXW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

@@ design/rdl_back.sv @@
// ----------------------------------------------------------------------------
// rdl_back: hit distance, disk test and density
// A bit-per-stage divider gives t, a few stages test the hit point against
// the radius, and a second bit-per-stage divider gives the density.
// ----------------------------------------------------------------------------
module rdl_back (
  input  logic               clk,
  input  logic               rst_n,
  input  rdl_pkg::disk_cfg_t disk,
  input  logic               head_valid,
  input  rdl_pkg::ray_word_t head_word,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit,
  output logic [31:0]        out_density,
  output logic [30:0]        out_hit_distance
);
  import rdl_pkg::*;

  localparam int QSTEPS = 36;
  localparam int DSTEPS = 32;

  logic  adv;
  qdiv_t qs [QSTEPS+1];
  ddiv_t ds [DSTEPS+1];
  qdiv_t q0_r;

  // advance the whole back end while the output word can move on
  assign adv = !out_valid || out_ready;
  assign pop = adv && head_valid;

  // load: leading remainder, far hits miss
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q0_r.v <= 1'b0;
    end else if (adv) begin
      q0_r.v     <= head_valid;
      q0_r.miss  <= head_word.miss || ({5'b0, head_word.num[50:20]} >= head_word.den);
      q0_r.den   <= head_word.den;
      q0_r.nlo   <= head_word.num[19:0];
      q0_r.rem   <= {5'b0, head_word.num[50:20]};
      q0_r.quo   <= '0;
      q0_r.off_x <= head_word.off_x;
      q0_r.off_y <= head_word.off_y;
      q0_r.off_z <= head_word.off_z;
      q0_r.dir_x <= head_word.dir_x;
      q0_r.dir_y <= head_word.dir_y;
      q0_r.dir_z <= head_word.dir_z;
    end
  end
  assign qs[0] = q0_r;

  // distance divider: one quotient bit per stage
  for (genvar s = 1; s <= QSTEPS; s++) begin : g_qdiv
    localparam int K = QSTEPS - s;
    logic        nbit;
    logic [36:0] trial;
    logic        ge;
    qdiv_t       nxt;
    qdiv_t       stage_r;

    if (K >= 16) begin : g_num
      assign nbit = qs[s-1].nlo[K-16];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    always_comb begin
      trial   = {qs[s-1].rem, nbit};
      ge      = trial >= {1'b0, qs[s-1].den};
      nxt     = qs[s-1];
      nxt.rem = ge ? 36'(trial - {1'b0, qs[s-1].den}) : trial[35:0];
      nxt.quo = {qs[s-1].quo[34:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_r.v <= 1'b0;
      end else if (adv) begin
        stage_r <= nxt;
      end
    end
    assign qs[s] = stage_r;
  end

  // E1: hit point products, q squared halves, density denominator parts
  logic               e1_v_r, e1_miss_r;
  logic [35:0]        e1_quo_r;
  logic signed [32:0] e1_off_x_r, e1_off_y_r, e1_off_z_r;
  logic signed [54:0] e1_px_r, e1_py_r, e1_pz_r;
  logic [53:0]        e1_qa_r, e1_qb_r;
  logic [62:0]        e1_pp0_r, e1_pp1_r, e1_pp2_r;
  qdiv_t              qe;

  assign qe = qs[QSTEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
    end else if (adv) begin
      e1_v_r     <= qe.v;
      e1_miss_r  <= qe.miss;
      e1_quo_r   <= qe.quo;
      e1_off_x_r <= qe.off_x;
      e1_off_y_r <= qe.off_y;
      e1_off_z_r <= qe.off_z;
      e1_px_r    <= $signed({1'b0, qe.quo}) * qe.dir_x;
      e1_py_r    <= $signed({1'b0, qe.quo}) * qe.dir_y;
      e1_pz_r    <= $signed({1'b0, qe.quo}) * qe.dir_z;
      e1_qa_r    <= qe.quo * qe.quo[17:0];
      e1_qb_r    <= qe.quo * qe.quo[35:18];
      e1_pp0_r   <= disk.pi_rad_sq[26:0] * qe.den;
      e1_pp1_r   <= disk.pi_rad_sq[53:27] * qe.den;
      e1_pp2_r   <= {1'b0, disk.pi_rad_sq[79:54]} * qe.den;
    end
  end

  // E2: offsets from the centre in the disk plane, radius box test
  logic signed [39:0] dl_x, dl_y, dl_z;
  logic [39:0]        mg_x, mg_y, mg_z;
  logic               oob;
  logic               e2_v_r, e2_miss_r;
  logic [35:0]        e2_quo_r;
  logic [30:0]        e2_m_x_r, e2_m_y_r, e2_m_z_r;
  logic [71:0]        e2_qq_r;
  logic [115:0]       e2_dn_r;

  always_comb begin
    dl_x = 40'(e1_off_x_r) + 40'(e1_px_r >>> 16);
    dl_y = 40'(e1_off_y_r) + 40'(e1_py_r >>> 16);
    dl_z = 40'(e1_off_z_r) + 40'(e1_pz_r >>> 16);
    mg_x = dl_x[39] ? 40'(-dl_x) : 40'(dl_x);
    mg_y = dl_y[39] ? 40'(-dl_y) : 40'(dl_y);
    mg_z = dl_z[39] ? 40'(-dl_z) : 40'(dl_z);
    oob  = (mg_x > {9'b0, disk.radius}) || (mg_y > {9'b0, disk.radius}) ||
           (mg_z > {9'b0, disk.radius});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e2_v_r <= 1'b0;
    end else if (adv) begin
      e2_v_r    <= e1_v_r;
      e2_miss_r <= e1_miss_r || oob;
      e2_quo_r  <= e1_quo_r;
      e2_m_x_r  <= mg_x[30:0];
      e2_m_y_r  <= mg_y[30:0];
      e2_m_z_r  <= mg_z[30:0];
      e2_qq_r   <= 72'(e1_qa_r) + {e1_qb_r, 18'b0};
      e2_dn_r   <= 116'(e1_pp0_r) + 116'({e1_pp1_r, 27'b0}) + {e1_pp2_r[61:0], 54'b0};
    end
  end

  // E3: squares of the in-plane offsets
  logic         e3_v_r, e3_miss_r;
  logic [35:0]  e3_quo_r;
  logic [61:0]  e3_sx_r, e3_sy_r, e3_sz_r;
  logic [71:0]  e3_qq_r;
  logic [115:0] e3_dn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e3_v_r <= 1'b0;
    end else if (adv) begin
      e3_v_r    <= e2_v_r;
      e3_miss_r <= e2_miss_r;
      e3_quo_r  <= e2_quo_r;
      e3_sx_r   <= e2_m_x_r * e2_m_x_r;
      e3_sy_r   <= e2_m_y_r * e2_m_y_r;
      e3_sz_r   <= e2_m_z_r * e2_m_z_r;
      e3_qq_r   <= e2_qq_r;
      e3_dn_r   <= e2_dn_r;
    end
  end

  // E4: squared distance from the centre
  logic         e4_v_r, e4_miss_r;
  logic [35:0]  e4_quo_r;
  logic [63:0]  e4_dist_r;
  logic [71:0]  e4_qq_r;
  logic [115:0] e4_dn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e4_v_r <= 1'b0;
    end else if (adv) begin
      e4_v_r    <= e3_v_r;
      e4_miss_r <= e3_miss_r;
      e4_quo_r  <= e3_quo_r;
      e4_dist_r <= 64'(e3_sx_r) + 64'(e3_sy_r) + 64'(e3_sz_r);
      e4_qq_r   <= e3_qq_r;
      e4_dn_r   <= e3_dn_r;
    end
  end

  // density load: disc test, saturation test and leading remainder
  logic [115:0] r0;
  ddiv_t        d0_r;

  assign r0 = {12'b0, e4_qq_r, 32'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d0_r.v <= 1'b0;
    end else if (adv) begin
      d0_r.v    <= e4_v_r;
      d0_r.miss <= e4_miss_r || (e4_dist_r > {2'b0, disk.rad_sq});
      d0_r.sat  <= r0 >= e4_dn_r;
      d0_r.quo  <= e4_quo_r;
      d0_r.dn   <= e4_dn_r;
      d0_r.rem  <= r0;
      d0_r.dq   <= '0;
    end
  end
  assign ds[0] = d0_r;

  // density divider: one quotient bit per stage
  for (genvar s = 1; s <= DSTEPS; s++) begin : g_ddiv
    logic [116:0] trial;
    logic         ge;
    ddiv_t        nxt;
    ddiv_t        stage_r;

    always_comb begin
      trial   = {ds[s-1].rem, 1'b0};
      ge      = trial >= {1'b0, ds[s-1].dn};
      nxt     = ds[s-1];
      nxt.rem = ge ? 116'(trial - {1'b0, ds[s-1].dn}) : trial[115:0];
      nxt.dq  = {ds[s-1].dq[30:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_r.v <= 1'b0;
      end else if (adv) begin
        stage_r <= nxt;
      end
    end
    assign ds[s] = stage_r;
  end

  // output word: zero on miss, clamp on overflow
  ddiv_t       de;
  logic        out_v_r;
  logic        hit_r;
  logic [31:0] dens_r;
  logic [30:0] dist_r;

  assign de = ds[DSTEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= de.v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r <= !de.miss;
      if (de.miss) begin
        dens_r <= '0;
        dist_r <= '0;
      end else begin
        dens_r <= de.sat ? DENS_MAX : de.dq;
        dist_r <= (de.quo[35:31] != '0) ? DIST_MAX : de.quo[30:0];
      end
    end
  end

  assign out_valid        = out_v_r;
  assign out_hit          = hit_r;
  assign out_density      = dens_r;
  assign out_hit_distance = dist_r;

endmodule

@@ design/ray_disk_light_pdf.sv @@
// ----------------------------------------------------------------------------
// ray_disk_light_pdf: one-sided disk light intersection and solid-angle pdf
// Intersects Q16.16 rays with a configured disk and returns the hit flag,
// the solid-angle density and the hit distance.
// ----------------------------------------------------------------------------
//   port group   dir   handshake            payload
//   in_*         in    in_valid/in_ready    origin x/y/z, direction x/y/z
//   out_*        out   out_valid/out_ready  hit, density, hit_distance
//   cfg_*        in    cfg_wr_en            cfg_index, cfg_wdata
//
// One ray word per cycle unless the queue fills or the output stalls. The
// pipeline length from input accept to output valid is set mostly by the
// two bit-per-stage dividers (36 stages for t, 32 for the density). Derived
// radius terms settle through rad_sq, pi_lo/pi_hi and pi_rad_sq after a radius write.
// Reset clears all valid flags and the queue, and sets the configuration registers to their defaults.
// A stalled output holds the back end; the queue lets the front keep taking
// words until it fills.
// ----------------------------------------------------------------------------
module ray_disk_light_pdf #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [17:0] in_dir_x,
  input  logic signed [17:0] in_dir_y,
  input  logic signed [17:0] in_dir_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit,
  output logic [31:0]        out_density,
  output logic [30:0]        out_hit_distance,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import rdl_pkg::*;

  geom_cfg_t   geom_r;
  logic [30:0] radius_r;
  logic [61:0] rad_sq_r;
  logic [48:0] pi_lo_r, pi_hi_r;
  logic [79:0] pi_rad_sq_r;
  disk_cfg_t   disk;
  logic        push_valid, full, not_empty, pop;
  ray_word_t   push_word, head_word;

  // register writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r.cx <= '0;
      geom_r.cy <= '0;
      geom_r.cz <= '0;
      geom_r.nx <= '0;
      geom_r.ny <= '0;
      geom_r.nz <= -18'sd65536;
      radius_r  <= 31'd65536;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_X: geom_r.cx <= cfg_wdata;
        REG_CENTER_Y: geom_r.cy <= cfg_wdata;
        REG_CENTER_Z: geom_r.cz <= cfg_wdata;
        REG_NORMAL_X: geom_r.nx <= cfg_wdata[17:0];
        REG_NORMAL_Y: geom_r.ny <= cfg_wdata[17:0];
        REG_NORMAL_Z: geom_r.nz <= cfg_wdata[17:0];
        REG_RADIUS:   radius_r  <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // derive pi * r^2 over three stages
  always_ff @(posedge clk) begin
    rad_sq_r    <= radius_r * radius_r;
    pi_lo_r     <= PI_Q16 * rad_sq_r[30:0];
    pi_hi_r     <= PI_Q16 * rad_sq_r[61:31];
    pi_rad_sq_r <= 80'(pi_lo_r) + {pi_hi_r[48:0], 31'b0};
  end

  assign disk.radius    = radius_r;
  assign disk.rad_sq    = rad_sq_r;
  assign disk.pi_rad_sq = pi_rad_sq_r;

  rdl_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_origin_x (in_origin_x),
    .in_origin_y (in_origin_y),
    .in_origin_z (in_origin_z),
    .in_dir_x    (in_dir_x),
    .in_dir_y    (in_dir_y),
    .in_dir_z    (in_dir_z),
    .geom        (geom_r),
    .push_ok     (!full),
    .push_valid  (push_valid),
    .push_word   (push_word)
  );

  rdl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_word (push_word),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head_word (head_word)
  );

  rdl_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .disk             (disk),
    .head_valid       (not_empty),
    .head_word        (head_word),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_density      (out_density),
    .out_hit_distance (out_hit_distance)
  );

endmodule

@@ tb/ray_disk_light_pdf_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_disk_light_pdf_tb: self-checking bench for the disk light intersector
// Drives rays through the valid/ready input and predicts each result word
// from its own copy of the disk registers. Starts with a short table of
// probes, then sends random rays that are mostly aimed at the disk, over
// several disk settings and idling patterns.
// ----------------------------------------------------------------------------
module ray_disk_light_pdf_tb;
  import rdl_pkg::*;

  localparam logic [2:0] REG_SPARE = 3'd7;  // index with no register behind it
  localparam int ONE = 65536;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic signed [17:0] dz;
  } ray_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] density;
    logic [30:0] hit_dist;
  } pdf_t;

  typedef struct packed {
    ray_t ray;
    logic typed;
    pdf_t want;
  } probe_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [17:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic [31:0] out_density;
  logic [30:0] out_hit_distance;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  // disk registers as the bench believes them to be
  logic signed [31:0] disk_ctr [3];
  logic signed [17:0] disk_nrm [3];
  logic [30:0] disk_rad;

  pdf_t pending_pdf_q [$];
  probe_t probes [$];
  int mismatch_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  ray_disk_light_pdf uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_origin_x(in_origin_x), .in_origin_y(in_origin_y), .in_origin_z(in_origin_z),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hit(out_hit), .out_density(out_density), .out_hit_distance(out_hit_distance),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  // Solid-angle pdf of one ray against the current disk
  function automatic pdf_t disk_pdf_of(ray_t r);
    longint o [3], d [3], c [3], n [3];
    longint dn, num, dlt, q_s;
    logic [63:0] bigd, bign, qi, q, m, dsq, rd;
    logic [127:0] qw;
    logic [191:0] top, den, lim;
    pdf_t res;
    res = '0;
    o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
    d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
    for (int i = 0; i < 3; i++) begin
      c[i] = disk_ctr[i];
      n[i] = disk_nrm[i];
    end
    dn = 0;
    num = 0;
    for (int i = 0; i < 3; i++) begin
      dn += d[i] * n[i];
      num += (c[i] - o[i]) * n[i];
    end
    // ray must face against the normal, with the plane ahead of it
    if (dn >= 0 || num > 0) return res;
    bigd = -dn;
    bign = -num;
    qi = bign / bigd;
    if (qi >= (64'd1 << 20)) return res;
    qw = ({64'd0, bign} << 16) / bigd;
    q = qw[63:0];
    q_s = q;
    rd = disk_rad;
    dsq = 0;
    for (int i = 0; i < 3; i++) begin
      dlt = (o[i] - c[i]) + ((q_s * d[i]) >>> 16);
      m = (dlt < 0) ? -dlt : dlt;
      if (m > rd) return res;
      dsq += m * m;
    end
    if (dsq > rd * rd) return res;
    top = q;
    top = top * top;
    top = top << 64;
    den = PI_Q16;
    den = den * rd;
    den = den * rd;
    den = den * bigd;
    lim = den << 32;
    res.hit = 1'b1;
    if (lim <= top) res.density = DENS_MAX;
    else res.density = 32'(top / den);
    res.hit_dist = (q > 64'(DIST_MAX)) ? DIST_MAX : q[30:0];
    return res;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= 40)
      $display("tb: mismatch on %s: got %h, want %h", what, got, want);
  endtask

  // Write one register and mirror it; caller lowers the enable
  task automatic write_disk_reg(logic [2:0] idx, logic [31:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      REG_CENTER_X: disk_ctr[0] = v;
      REG_CENTER_Y: disk_ctr[1] = v;
      REG_CENTER_Z: disk_ctr[2] = v;
      REG_NORMAL_X: disk_nrm[0] = v[17:0];
      REG_NORMAL_Y: disk_nrm[1] = v[17:0];
      REG_NORMAL_Z: disk_nrm[2] = v[17:0];
      REG_RADIUS:   disk_rad = v[30:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_disk(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                            logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                            logic [31:0] rad);
    write_disk_reg(REG_CENTER_X, cx);
    write_disk_reg(REG_CENTER_Y, cy);
    write_disk_reg(REG_CENTER_Z, cz);
    write_disk_reg(REG_NORMAL_X, nx);
    write_disk_reg(REG_NORMAL_Y, ny);
    write_disk_reg(REG_NORMAL_Z, nz);
    write_disk_reg(REG_RADIUS, rad);
    cfg_wr_en <= 1'b0;
    // let the derived radius terms settle
    repeat (8) @(posedge clk);
  endtask

  // Offer one ray word and hold it until taken
  task automatic offer_ray(ray_t r, logic typed, pdf_t want);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_origin_x <= r.ox;
    in_origin_y <= r.oy;
    in_origin_z <= r.oz;
    in_dir_x <= r.dx;
    in_dir_y <= r.dy;
    in_dir_z <= r.dz;
    do @(posedge clk); while (!in_ready);
    pending_pdf_q.push_back(typed ? want : disk_pdf_of(r));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_pdf_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic add_probe(int ox, int oy, int oz, int dx, int dy, int dz,
                           logic typed, logic hit, logic [31:0] dens, logic [30:0] want_dist);
    probe_t p;
    p.ray = {32'(ox), 32'(oy), 32'(oz), 18'(dx), 18'(dy), 18'(dz)};
    p.typed = typed;
    p.want = {hit, dens, want_dist};
    probes.push_back(p);
  endtask

  task automatic walk_probes;
    foreach (probes[i]) offer_ray(probes[i].ray, probes[i].typed, probes[i].want);
    probes.delete();
  endtask

  function automatic real rnd(real lo, real hi);
    return lo + (hi - lo) * ($urandom / 4294967295.0);
  endfunction

  function automatic logic signed [31:0] to_q(real x);
    real s;
    s = x * 65536.0;
    if (s > 2147483647.0) return 32'h7FFF_FFFF;
    if (s < -2147483648.0) return 32'h8000_0000;
    return $rtoi(s);
  endfunction

  // Mostly rays aimed at or near the disk; the rest is raw noise
  function automatic ray_t make_ray();
    real c [3], nv [3], t1 [3], t2 [3], p [3], o [3], w [3];
    real nl, wl, rr, s1, s2, h;
    ray_t r;
    for (int i = 0; i < 3; i++) begin
      c[i] = real'(disk_ctr[i]) / 65536.0;
      nv[i] = real'(disk_nrm[i]) / 65536.0;
    end
    nl = $sqrt(nv[0] * nv[0] + nv[1] * nv[1] + nv[2] * nv[2]);
    if ($urandom_range(99) < 25 || nl == 0.0) begin
      r = {$urandom, $urandom, $urandom, 18'($urandom), 18'($urandom), 18'($urandom)};
      if ($urandom_range(1)) begin
        r.ox = disk_ctr[0] + 32'($urandom_range(0, 2 * ONE)) - ONE;
        r.oy = disk_ctr[1] + 32'($urandom_range(0, 2 * ONE)) - ONE;
        r.oz = disk_ctr[2] + 32'($urandom_range(0, 2 * ONE)) - ONE;
      end
      return r;
    end
    for (int i = 0; i < 3; i++) nv[i] = nv[i] / nl;
    rr = real'(disk_rad) / 65536.0;
    // tangent frame of the disk
    if (nv[0] > 0.9 || nv[0] < -0.9) begin
      t1[0] = nv[2]; t1[1] = 0.0; t1[2] = -nv[0];
    end else begin
      t1[0] = 0.0; t1[1] = -nv[2]; t1[2] = nv[1];
    end
    wl = $sqrt(t1[0] * t1[0] + t1[1] * t1[1] + t1[2] * t1[2]);
    for (int i = 0; i < 3; i++) t1[i] = t1[i] / wl;
    t2[0] = nv[1] * t1[2] - nv[2] * t1[1];
    t2[1] = nv[2] * t1[0] - nv[0] * t1[2];
    t2[2] = nv[0] * t1[1] - nv[1] * t1[0];
    s1 = rnd(-0.9, 0.9);
    s2 = rnd(-0.9, 0.9);
    h = rnd(0.01, 60.0);
    for (int i = 0; i < 3; i++) begin
      p[i] = c[i] + rr * (s1 * t1[i] + s2 * t2[i]);
      o[i] = p[i] + h * nv[i] + rnd(-20.0, 20.0) * (t1[i] + t2[i]) * 0.5;
      w[i] = p[i] - o[i];
    end
    wl = $sqrt(w[0] * w[0] + w[1] * w[1] + w[2] * w[2]);
    if (wl == 0.0) wl = 1.0;
    r.ox = to_q(o[0]);
    r.oy = to_q(o[1]);
    r.oz = to_q(o[2]);
    r.dx = 18'($rtoi(w[0] / wl * 65536.0));
    r.dy = 18'($rtoi(w[1] / wl * 65536.0));
    r.dz = 18'($rtoi(w[2] / wl * 65536.0));
    return r;
  endfunction

  task automatic run_rays(int count);
    for (int k = 0; k < count; k++) offer_ray(make_ray(), 1'b0, '0);
    drain();
  endtask

  // Count down the long receiver hold-off
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Take result words, check them and pick the next ready
  always @(posedge clk) begin
    pdf_t want;
    if (out_valid && out_ready) begin
      if (pending_pdf_q.size() == 0) begin
        flag_mismatch("unexpected word", {31'd0, out_hit}, '0);
      end else begin
        want = pending_pdf_q.pop_front();
        if (out_hit !== want.hit) flag_mismatch("hit", {31'd0, out_hit}, {31'd0, want.hit});
        if (out_density !== want.density) flag_mismatch("density", out_density, want.density);
        if (out_hit_distance !== want.hit_dist)
          flag_mismatch("hit_distance", {1'b0, out_hit_distance}, {1'b0, want.hit_dist});
      end
    end
    out_ready <= rst_n && (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    disk_ctr[0] = '0; disk_ctr[1] = '0; disk_ctr[2] = '0;
    disk_nrm[0] = '0; disk_nrm[1] = '0; disk_nrm[2] = -18'sd65536;
    disk_rad = 31'd65536;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    // probes against the reset disk: unit disk at the origin facing -z
    add_probe(0, 0, -ONE, 0, 0, ONE, 0, 0, 0, 0);
    add_probe(0, 0, 0, 0, 0, ONE, 1, 1, 0, 0);                  // hit at origin
    add_probe(0, 0, -ONE, 0, 0, 0, 1, 0, 0, 0);                 // zero direction
    add_probe(0, 0, -ONE, 0, 0, -ONE, 1, 0, 0, 0);              // faces away
    add_probe(0, 0, ONE, 0, 0, ONE, 1, 0, 0, 0);                // disk behind
    add_probe(0, 0, 32'h8000_0000, ONE, 0, 1, 1, 0, 0, 0);      // far hit
    add_probe(32'h7FFF_FFFF, 32'h8000_0000, -ONE, 0, 0, ONE, 0, 0, 0, 0);
    add_probe(0, 0, -2 * ONE, 18'h1FFFF, 18'h20000, 18'h1FFFF, 0, 0, 0, 0);
    add_probe(0, 0, -ONE - ONE / 2, 32768, 0, 56756, 0, 0, 0, 0);
    add_probe(2 * ONE, 0, -ONE, 0, 0, ONE, 1, 0, 0, 0);         // outside radius
    add_probe(ONE, 0, -ONE, 0, 0, ONE, 0, 0, 0, 0);             // on the rim
    add_probe(ONE, 1, -ONE, 0, 0, ONE, 1, 0, 0, 0);             // just past rim
    add_probe(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, -ONE, -ONE, ONE, 0, 0, 0, 0);
    walk_probes();
    drain();

    // no idling, reset disk
    run_rays(180);

    // sender idle most of the time, tilted disk
    send_idle_pct = 80;
    apply_disk(32'h0003_8000, 32'hFFFE_0000, 32'h0000_4000,
               32'h0000_93CD, 32'hFFFF_6C33, 32'h0000_0000, 32'h0002_8000);
    run_rays(170);

    // receiver stalling, widest radius, center at the ends of the range
    send_idle_pct = 0;
    recv_stall_pct = 80;
    apply_disk(32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000,
               32'hFFFD_0000 | 32'h0001_0000, 32'h0, 32'h0, 32'h7FFF_FFFF);
    run_rays(170);

    // both idling, smallest nonzero radius, normal along +y
    send_idle_pct = 35;
    recv_stall_pct = 35;
    apply_disk(32'h8000_0000, 32'h0010_0000, 32'h0000_0000,
               32'h0, 32'h0001_0000, 32'h0, 32'd1);
    run_rays(120);

    // non-unit normal with junk in the upper data bits, moderate radius
    apply_disk(32'h0000_1234, 32'hFFFF_0000, 32'h0020_0000,
               32'hABC3_FFFF, 32'h5552_0001, 32'hFFFE_8000, 32'h0010_0000);
    write_disk_reg(REG_SPARE, 32'hFFFF_FFFF);
    cfg_wr_en <= 1'b0;
    repeat (4) @(posedge clk);
    run_rays(120);

    // zero radius saturates the density of an exact centre hit
    apply_disk(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0);
    add_probe(0, 0, -ONE, 0, 0, ONE, 1, 1, DENS_MAX, 31'd65536);
    walk_probes();
    run_rays(30);

    // long receiver hold-off while rays keep coming; enough rays to fill
    // the whole pipeline and stall the input
    send_idle_pct = 0;
    recv_stall_pct = 0;
    apply_disk(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0001_0000);
    hold_left <= 400;
    run_rays(150);

    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
